/* design/neighbour_mean_filter_3x3_assert.svh */
// ----------------------------------------------------------------------------
// neighbour_mean_filter_3x3_assert.svh
// Assertion shorthands for the neighbour mean filter checker.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_MEAN_FILTER_3X3_ASSERT_SVH
`define NEIGHBOUR_MEAN_FILTER_3X3_ASSERT_SVH

// consequent checked in the same cycle, ignored while in reset
`define NMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmf assertion failed");

// consequent checked in the following cycle, ignored while in reset
`define NMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmf assertion failed");

// consequent checked in the following cycle, also across reset
`define NMF_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nmf reset assertion failed");

`endif

/* design/nmf_pkg.sv */
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared widths, constants and types of the 3x3 neighbour mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nmf_pkg;

  // sizing
  localparam int MAX_COLS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int ROW_W      = 16;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int NCOL_W     = $clog2(MAX_COLS + 1);
  localparam int CFG_ROWS_W = 16;
  localparam int CFG_COLS_W = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int MEAN_W     = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  // eight neighbours summed: three extra bits
  localparam int SUM_W = SAMPLE_BITS + 3;

  // divide by 3, 5 or 8 through one reciprocal multiply
  // dividend is |sum| << FRAC_BITS, below 2^(SUM_W+FRAC_BITS)
  localparam int RECIP_K   = SUM_W + FRAC_BITS + 3;
  localparam int MUL_W     = RECIP_K - 1;
  localparam int PROD_W    = SUM_W + MUL_W;
  localparam int QUO_SHIFT = RECIP_K - FRAC_BITS;

  localparam logic [MUL_W-1:0] RECIP_3 =
    MUL_W'(((64'd1 << RECIP_K) + 64'd2) / 64'd3);
  localparam logic [MUL_W-1:0] RECIP_5 =
    MUL_W'(((64'd1 << RECIP_K) + 64'd4) / 64'd5);
  localparam logic [MUL_W-1:0] RECIP_8 =
    MUL_W'(64'd1 << (RECIP_K - 3));

  // one column of the 3-row window: top is the oldest row
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] top;
    logic signed [SAMPLE_BITS-1:0] mid;
    logic signed [SAMPLE_BITS-1:0] bot;
  } col_t;

  // position and flags that travel with a result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             run_last;
    logic             frame_done;
  } tag_t;

endpackage

`default_nettype wire

/* design/nmf_line_cell.sv */
// ----------------------------------------------------------------------------
// nmf_line_cell
// One column cell of a shift chain: takes its neighbor's column, or the
// injected column when it is the entry point of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_line_cell (
  input  wire  logic          clk,
  input  wire  logic          shift_en,
  input  wire  logic          take_inj,
  input  wire  nmf_pkg::col_t inj,
  input  wire  nmf_pkg::col_t prev,
  output       nmf_pkg::col_t cell_q
);

  // column register, moves one place per shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_q <= take_inj ? inj : prev;
    end
  end

endmodule

`default_nettype wire

/* design/nmf_mean_unit.sv */
// ----------------------------------------------------------------------------
// nmf_mean_unit
// Masked neighbour sum, divide by 3/5/8 in Q format and output register.
// Three stages; the whole pipe advances together on adv.
// ----------------------------------------------------------------------------
`default_nettype none

module nmf_mean_unit (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst,
  input  wire  logic                                 adv,
  input  wire  logic                                 step_emit,
  input  wire  nmf_pkg::tag_t                        step_tag,
  input  wire  nmf_pkg::col_t                        left,
  input  wire  nmf_pkg::col_t                        center,
  input  wire  nmf_pkg::col_t                        right,
  input  wire  logic [nmf_pkg::ROW_W-1:0]            rows_eff,
  input  wire  logic [nmf_pkg::NCOL_W-1:0]           cols_eff,
  output       logic                                 out_valid,
  output       logic signed [nmf_pkg::MEAN_W-1:0]    mean,
  output       nmf_pkg::tag_t                        out_tag
);

  localparam logic [1:0] DIV_CORNER   = 2'd0;
  localparam logic [1:0] DIV_EDGE     = 2'd1;
  localparam logic [1:0] DIV_INTERIOR = 2'd2;

  // sample if inside the frame, else zero
  function automatic logic signed [nmf_pkg::SUM_W-1:0] pick(
    input logic on, input logic signed [nmf_pkg::SAMPLE_BITS-1:0] v);
    return on ? nmf_pkg::SUM_W'(v) : '0;
  endfunction

  logic                               top_on, bot_on, left_on, right_on;
  logic                               rend, cend;
  logic signed [nmf_pkg::SUM_W-1:0]   sum_next;
  logic [1:0]                         div_next;

  logic                               v1;
  logic signed [nmf_pkg::SUM_W-1:0]   sum1;
  logic [1:0]                         div1;
  nmf_pkg::tag_t                      tag1;

  logic [nmf_pkg::SUM_W-1:0]          mag;
  logic [nmf_pkg::MUL_W-1:0]          recip;

  logic                               v2;
  logic [nmf_pkg::PROD_W-1:0]         prod2;
  logic                               neg2;
  nmf_pkg::tag_t                      tag2;

  logic [nmf_pkg::MEAN_W-1:0]         q_lo;
  logic [nmf_pkg::MEAN_W-1:0]         mean_next;

  // frame bounds of the result position
  always_comb begin
    top_on   = (step_tag.row != '0);
    bot_on   = (step_tag.row != rows_eff - nmf_pkg::ROW_W'(1));
    left_on  = (step_tag.col != '0);
    right_on = (nmf_pkg::NCOL_W'(step_tag.col) != cols_eff - nmf_pkg::NCOL_W'(1));
    rend     = !top_on || !bot_on;
    cend     = !left_on || !right_on;
    if (rend && cend) begin
      div_next = DIV_CORNER;
    end else if (rend || cend) begin
      div_next = DIV_EDGE;
    end else begin
      div_next = DIV_INTERIOR;
    end
  end

  // eight neighbours, centre left out
  always_comb begin
    sum_next = pick(left_on && top_on, left.top) + pick(left_on, left.mid)
             + pick(left_on && bot_on, left.bot)
             + pick(top_on, center.top) + pick(bot_on, center.bot)
             + pick(right_on && top_on, right.top) + pick(right_on, right.mid)
             + pick(right_on && bot_on, right.bot);
  end

  // magnitude and reciprocal for the multiply stage
  always_comb begin
    mag = sum1[nmf_pkg::SUM_W-1] ? (~sum1 + 1'b1) : sum1;
    case (div1)
      DIV_CORNER: recip = nmf_pkg::RECIP_3;
      DIV_EDGE:   recip = nmf_pkg::RECIP_5;
      default:    recip = nmf_pkg::RECIP_8;
    endcase
  end

  // quotient, sign restored; truncation toward zero
  always_comb begin
    q_lo      = prod2[nmf_pkg::QUO_SHIFT +: nmf_pkg::MEAN_W];
    mean_next = neg2 ? (~q_lo + 1'b1) : q_lo;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= step_emit;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      sum1    <= sum_next;
      div1    <= div_next;
      tag1    <= step_tag;
      prod2   <= mag * recip;
      neg2    <= sum1[nmf_pkg::SUM_W-1];
      tag2    <= tag1;
      mean    <= $signed(mean_next);
      out_tag <= tag2;
    end
  end

endmodule

`default_nettype wire

/* design/neighbour_mean_filter_3x3.sv */
// ----------------------------------------------------------------------------
// neighbour_mean_filter_3x3
// 3x3 mean of the eight neighbours (centre excluded) over a raster stream,
// divided by 3 at corners, 5 at edges and 8 inside, given in Q8.
// ----------------------------------------------------------------------------
// Samples enter in raster order, one per cycle while the result side keeps
// up. Each result trails its input by one row and one column and passes the
// sum, multiply and output registers after the step that forms it. The last
// column of every row after the first yields two results, the second in an
// extra step; the last sample of a frame is followed by a fill step and one
// drain step per column of the final row. No sample is taken meanwhile. The
// line store is a ring of MAX_COLS column cells, each holding one column of
// the last three rows; its length follows frame_cols and it needs no
// clearing after reset. Writing either size register restarts the frame.
`default_nettype none

module neighbour_mean_filter_3x3 (
  input  wire  logic                                   clk,
  input  wire  logic                                   rst,
  input  wire  logic                                   cfg_wen,
  input  wire  logic [nmf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  logic [nmf_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire  logic                                   in_valid,
  output       logic                                   in_stall,
  input  wire  logic signed [nmf_pkg::SAMPLE_BITS-1:0] sample,
  output       logic                                   out_valid,
  input  wire  logic                                   out_stall,
  output       logic signed [nmf_pkg::MEAN_W-1:0]      mean_q8,
  output       logic [nmf_pkg::ROW_W-1:0]              out_row,
  output       logic [nmf_pkg::COL_W-1:0]              out_col,
  output       logic                                   run_last,
  output       logic                                   frame_done
);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_EDGE  = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]                        state, state_next;
  logic [nmf_pkg::ROW_W-1:0]         row_count;
  logic [nmf_pkg::COL_W-1:0]         col_count;
  logic [nmf_pkg::ROW_W-1:0]         rows_eff;
  logic [nmf_pkg::NCOL_W-1:0]        cols_eff;
  logic [nmf_pkg::ROW_W-1:0]         held_row;
  logic                              held_end;
  logic [nmf_pkg::COL_W-1:0]         drain_col;

  logic                              adv, take_in;
  logic                              last_col, last_row, drain_last;
  logic [nmf_pkg::CFG_COLS_W-1:0]    cols_wr;

  logic                              step, step_emit, ring_shift;
  nmf_pkg::tag_t                     step_tag;
  nmf_pkg::col_t                     step_col, ring_inj, new_col, drain_val;
  nmf_pkg::col_t                     ring [nmf_pkg::MAX_COLS];
  nmf_pkg::col_t                     ring_tap;
  nmf_pkg::col_t                     win0, win1;
  logic [nmf_pkg::NCOL_W-1:0]        ring_ins;
  nmf_pkg::tag_t                     res_tag;

  // handshake: one pipe enable for the whole result path
  assign adv      = !out_valid || !out_stall;
  assign in_stall = (state != ST_RUN) || !adv;
  assign take_in  = in_valid && !in_stall;

  // position flags
  assign last_col   = (nmf_pkg::NCOL_W'(col_count) == cols_eff - nmf_pkg::NCOL_W'(1));
  assign last_row   = (row_count >= rows_eff - nmf_pkg::ROW_W'(1));
  assign drain_last = (nmf_pkg::NCOL_W'(drain_col) == cols_eff - nmf_pkg::NCOL_W'(1));
  assign cols_wr    = cfg_data[nmf_pkg::CFG_COLS_W-1:0];

  // ring tap is the same column one row back
  assign ring_tap  = ring[nmf_pkg::MAX_COLS-1];
  assign ring_ins  = nmf_pkg::NCOL_W'(nmf_pkg::MAX_COLS) - cols_eff;
  assign new_col   = '{top: ring_tap.mid, mid: ring_tap.bot, bot: sample};
  assign drain_val = '{top: ring_tap.mid, mid: ring_tap.bot, bot: '0};

  // step sequencer
  always_comb begin
    step       = 1'b0;
    step_emit  = 1'b0;
    step_tag   = '0;
    step_col   = '0;
    ring_shift = 1'b0;
    ring_inj   = ring_tap;
    state_next = state;
    case (state)
      ST_RUN: begin
        if (take_in) begin
          step              = 1'b1;
          step_col          = new_col;
          ring_shift        = 1'b1;
          ring_inj          = new_col;
          step_emit         = (row_count != '0) && (col_count != '0);
          step_tag.row      = row_count - nmf_pkg::ROW_W'(1);
          step_tag.col      = col_count - nmf_pkg::COL_W'(1);
          step_tag.run_last = !(last_col && ((row_count != '0) || last_row));
          if (last_col && (row_count != '0)) begin
            state_next = ST_EDGE;
          end else if (last_col && last_row) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_EDGE: begin
        if (adv) begin
          step              = 1'b1;
          step_emit         = 1'b1;
          step_tag.row      = held_row - nmf_pkg::ROW_W'(1);
          step_tag.col      = nmf_pkg::COL_W'(cols_eff - nmf_pkg::NCOL_W'(1));
          step_tag.run_last = !held_end;
          state_next        = held_end ? ST_FILL : ST_RUN;
        end
      end
      ST_FILL: begin
        if (adv) begin
          step       = 1'b1;
          step_col   = drain_val;
          ring_shift = 1'b1;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          step                = 1'b1;
          step_emit           = 1'b1;
          step_col            = drain_val;
          ring_shift          = 1'b1;
          step_tag.row        = held_row;
          step_tag.col        = drain_col;
          step_tag.run_last   = drain_last;
          step_tag.frame_done = drain_last;
          if (drain_last) begin
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // control state, counters and size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      row_count <= '0;
      col_count <= '0;
      rows_eff  <= nmf_pkg::ROW_W'(2);
      cols_eff  <= nmf_pkg::NCOL_W'(2);
    end else begin
      state <= state_next;
      if (cfg_wen && (cfg_index == nmf_pkg::REG_FRAME_ROWS ||
                      cfg_index == nmf_pkg::REG_FRAME_COLS)) begin
        row_count <= '0;
        col_count <= '0;
        if (cfg_index == nmf_pkg::REG_FRAME_ROWS) begin
          rows_eff <= (cfg_data[nmf_pkg::CFG_ROWS_W-1:0] == '0) ? nmf_pkg::ROW_W'(1) :
                      cfg_data[nmf_pkg::CFG_ROWS_W-1:0];
        end else if (cols_wr == '0) begin
          cols_eff <= nmf_pkg::NCOL_W'(1);
        end else if (cols_wr > nmf_pkg::CFG_COLS_W'(nmf_pkg::MAX_COLS)) begin
          cols_eff <= nmf_pkg::NCOL_W'(nmf_pkg::MAX_COLS);
        end else begin
          cols_eff <= nmf_pkg::NCOL_W'(cols_wr);
        end
      end else if (take_in) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + nmf_pkg::ROW_W'(1);
        end else begin
          col_count <= col_count + nmf_pkg::COL_W'(1);
        end
      end
    end
  end

  // row and end flag of the last transfer, drain column
  always_ff @(posedge clk) begin
    if (take_in) begin
      held_row <= row_count;
      held_end <= last_col && last_row;
    end
    if (state == ST_FILL) begin
      drain_col <= '0;
    end else if (state == ST_DRAIN && adv) begin
      drain_col <= drain_col + nmf_pkg::COL_W'(1);
    end
  end

  // line store: ring of column cells, entry point set by frame width
  for (genvar k = 0; k < nmf_pkg::MAX_COLS; k++) begin : g_ring
    nmf_line_cell u_cell (
      .clk      (clk),
      .shift_en (ring_shift),
      .take_inj (ring_ins == nmf_pkg::NCOL_W'(k)),
      .inj      (ring_inj),
      .prev     ((k == 0) ? ring_inj : ring[(k == 0) ? 0 : k - 1]),
      .cell_q   (ring[k])
    );
  end

  // window: newest column and the one before it
  nmf_line_cell u_win0 (
    .clk      (clk),
    .shift_en (step),
    .take_inj (1'b1),
    .inj      (step_col),
    .prev     (step_col),
    .cell_q   (win0)
  );

  nmf_line_cell u_win1 (
    .clk      (clk),
    .shift_en (step),
    .take_inj (1'b0),
    .inj      (step_col),
    .prev     (win0),
    .cell_q   (win1)
  );

  // sum, divide and output register
  nmf_mean_unit u_mean (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .step_emit (step && step_emit),
    .step_tag  (step_tag),
    .left      (win1),
    .center    (win0),
    .right     (step_col),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff),
    .out_valid (out_valid),
    .mean      (mean_q8),
    .out_tag   (res_tag)
  );

  assign out_row    = res_tag.row;
  assign out_col    = res_tag.col;
  assign run_last   = res_tag.run_last;
  assign frame_done = res_tag.frame_done;

endmodule

`default_nettype wire

/* design/nmf_checker.sv */
// ----------------------------------------------------------------------------
// nmf_checker
// Port-level checks for the neighbour mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "neighbour_mean_filter_3x3_assert.svh"

module nmf_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [nmf_pkg::MEAN_W-1:0]   mean_q8,
  input wire logic [nmf_pkg::ROW_W-1:0]           out_row,
  input wire logic [nmf_pkg::COL_W-1:0]           out_col,
  input wire logic                                run_last,
  input wire logic                                frame_done
);

  // whole result payload as one vector
  logic [nmf_pkg::MEAN_W+nmf_pkg::ROW_W+nmf_pkg::COL_W+1:0] res_bits;

  assign res_bits = {mean_q8, out_row, out_col, run_last, frame_done};

  // a stalled result stays offered and unchanged
  `NMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `NMF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(res_bits))

  // the end of a frame always closes a run
  `NMF_ASSERT_NOW(a_done_last, out_valid && frame_done, run_last)

  // reset leaves the result side empty and the input open
  `NMF_ASSERT_RESET(a_reset_empty, rst, !out_valid && !in_stall)

endmodule

bind neighbour_mean_filter_3x3 nmf_checker u_nmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .mean_q8    (mean_q8),
  .out_row    (out_row),
  .out_col    (out_col),
  .run_last   (run_last),
  .frame_done (frame_done)
);

`default_nettype wire
